// ----- rtl/drp2m_pkg.sv -----
// Package: shared types, constants and helpers for the power-of-two grid snapper
`default_nettype none
package drp2m_pkg;

    localparam int unsigned ValueWidth  = 64;
    localparam int unsigned LambdaWidth = 63;
    localparam int unsigned FracWidth   = 52;
    localparam int unsigned ExpWidth    = 11;
    localparam int unsigned SigWidth    = 53;
    // signed grid / value exponent range fits in 13 bits (-1074 .. 1024)
    localparam int unsigned GridWidth   = 13;

    localparam logic [ExpWidth-1:0] ExpAll = 11'h7FF;

    // stage 1 to stage 2 control
    typedef struct packed {
        logic                        pass;   // output the input unchanged
        logic                        sign;
        logic [SigWidth-1:0]         sig;
        logic [5:0]                  shift;  // 1..54 when not pass/zero
        logic                        zero;   // rounds to zero
    } s1_t;

    // stage 2 to stage 3 control
    typedef struct packed {
        logic                        pass;
        logic                        sign;
        logic                        zero;
        logic [SigWidth:0]           n;      // rounded integer, up to 54 bits
    } s2_t;

    // bit length of a 54-bit value
    function automatic logic [5:0] bit_len54(input logic [SigWidth:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i <= SigWidth; i++) begin
            if (v[i]) begin
                r = 6'(i + 1);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/double_round_to_power_of_two_multiple_unit.sv -----
// Top level: three-stage pipeline snapping doubles to a power-of-two grid
//
// Usage: value_bits enters on in_valid/in_stall, result_bits leaves on
// out_valid/out_stall. An item is taken on a rising edge with valid high
// and stall low. One result per item, in order.
// Three register stages: unpack and shift amount, round add and shift,
// normalise and pack; throughput is one item per cycle while out_stall is
// low. The user must see that lambda_bits is written through cfg_we/cfg_data
// only while the block is idle; the block does not enforce this. The grid
// exponent is taken at the write edge, so items may follow at once. Reset
// clears all valid bits and sets lambda to 1.0 (grid 2^0). When out_stall
// is high the full stages hold; in_stall follows so no item is lost or
// repeated. Gaps in the pipe are filled while stalled.
`default_nettype none
module double_round_to_power_of_two_multiple_unit (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [drp2m_pkg::LambdaWidth-1:0]   cfg_data,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic [drp2m_pkg::ValueWidth-1:0]    value_bits,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic [drp2m_pkg::ValueWidth-1:0]         result_bits
);
    logic signed [drp2m_pkg::GridWidth-1:0] grid_m;

    // config register, kept as its grid exponent
    drp2m_grid u_grid (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .grid_m     (grid_m)
    );

    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3;
    assign en3 = !v3_reg || !out_stall;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_stall = !en1;

    // stage 1: unpack and shift amount
    logic [drp2m_pkg::ExpWidth-1:0]  in_e;
    logic [drp2m_pkg::FracWidth-1:0] in_f;
    logic signed [drp2m_pkg::GridWidth-1:0] in_ex, diff;
    drp2m_pkg::s1_t s1_next, s1_reg;
    logic [drp2m_pkg::ValueWidth-1:0] x1_reg, x2_reg;
    logic signed [drp2m_pkg::GridWidth-1:0] m1_reg, m2_reg;

    assign in_e = value_bits[62:52];
    assign in_f = value_bits[51:0];
    assign in_ex = (in_e == '0) ? -13'sd1074 : ($signed({2'b00, in_e}) - 13'sd1075);
    assign diff = grid_m - in_ex;

    always_comb
    begin
        s1_next.sign = value_bits[63];
        s1_next.sig = (in_e == '0) ? {1'b0, in_f} : {1'b1, in_f};
        s1_next.pass = (in_e == drp2m_pkg::ExpAll) || (in_e == '0 && in_f == '0)
                       || (diff <= 13'sd0);
        s1_next.zero = (diff >= 13'sd55);
        s1_next.shift = (diff > 13'sd0 && diff < 13'sd55) ? diff[5:0] : 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
        end else if (en1) begin
            v1_reg <= in_valid;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en1) begin
            s1_reg <= s1_next;
            x1_reg <= value_bits;
            m1_reg <= grid_m;
        end
    end

    // stage 2: add half and shift down
    drp2m_pkg::s2_t s2_next, s2_reg;
    logic [drp2m_pkg::SigWidth:0] half, sum;
    always_comb
    begin
        half = 54'd1 << (s1_reg.shift - 6'd1);
        sum = {1'b0, s1_reg.sig} + half;
        s2_next.pass = s1_reg.pass;
        s2_next.sign = s1_reg.sign;
        s2_next.n = sum >> s1_reg.shift;
        s2_next.zero = s1_reg.zero || (s2_next.n == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v2_reg <= 1'b0;
        end else if (en2) begin
            v2_reg <= v1_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en2) begin
            s2_reg <= s2_next;
            x2_reg <= x1_reg;
            m2_reg <= m1_reg;
        end
    end

    // stage 3: normalise and pack
    logic [5:0] len;
    logic signed [drp2m_pkg::GridWidth-1:0] top, sub_sh;
    logic [drp2m_pkg::SigWidth:0] norm;
    logic [drp2m_pkg::ExpWidth-1:0] bexp;
    logic [drp2m_pkg::ValueWidth-1:0] res_next, res_reg;
    always_comb
    begin
        len = drp2m_pkg::bit_len54(s2_reg.n);
        top = m2_reg + $signed({7'd0, len}) - 13'sd1;
        sub_sh = m2_reg + 13'sd1074;
        norm = (len <= 6'd53) ? (s2_reg.n << (6'd53 - len)) : (s2_reg.n >> 1);
        bexp = 11'(top + 13'sd1023);
        if (s2_reg.pass) begin
            res_next = x2_reg;
        end else if (s2_reg.zero) begin
            res_next = {s2_reg.sign, 63'd0};
        end else if (top > 13'sd1023) begin
            res_next = {s2_reg.sign, drp2m_pkg::ExpAll, 52'd0};
        end else if (top >= -13'sd1022) begin
            res_next = {s2_reg.sign, bexp, norm[51:0]};
        end else begin
            res_next = {s2_reg.sign, 11'd0, 52'(s2_reg.n << sub_sh[5:0])};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v3_reg <= 1'b0;
        end else if (en3) begin
            v3_reg <= v2_reg;
        end
    end
    always_ff @(posedge clk)
    begin
        if (en3) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = v3_reg;
    assign result_bits = res_reg;

    // a held result stays while the receiver stalls
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(result_bits)))
        else $error("result changed under stall");
    // accepted item reaches stage one
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> v1_reg)
        else $error("accepted item lost");
    // pipeline only refuses input when fully blocked downstream
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v1_reg && v2_reg && v3_reg && out_stall))
        else $error("spurious input stall");
endmodule
`default_nettype wire

// ----- rtl/drp2m_grid.sv -----
// Grid exponent worked out from the written lambda and held in a register
`default_nettype none
module drp2m_grid (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [drp2m_pkg::LambdaWidth-1:0]      cfg_data,
    output logic signed [drp2m_pkg::GridWidth-1:0]      grid_m
);
    logic [drp2m_pkg::ExpWidth-1:0]  e;
    logic [drp2m_pkg::FracWidth-1:0] f;
    logic [5:0]                      len;
    logic signed [drp2m_pkg::GridWidth-1:0] m_next, grid_m_reg;

    assign e = cfg_data[62:52];
    assign f = cfg_data[51:0];
    assign len = drp2m_pkg::bit_len54({2'b00, f});

    // ceil(log2 lambda), with the saturated and zero cases
    always_comb
    begin
        if (e == drp2m_pkg::ExpAll) begin
            m_next = 13'sd1024;
        end else if (e == '0) begin
            if (f == '0) begin
                m_next = -13'sd1074;
            end else if ((f & (f - 52'd1)) == '0) begin
                m_next = $signed({7'd0, len}) - 13'sd1075;
            end else begin
                m_next = $signed({7'd0, len}) - 13'sd1074;
            end
        end else if (f == '0) begin
            m_next = $signed({2'b00, e}) - 13'sd1023;
        end else begin
            m_next = $signed({2'b00, e}) - 13'sd1022;
        end
    end

    // taken at the write edge; reset lambda of 1.0 gives grid 2^0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            grid_m_reg <= 13'sd0;
        end else if (cfg_we) begin
            grid_m_reg <= m_next;
        end
    end

    assign grid_m = grid_m_reg;
endmodule
`default_nettype wire

// ----- tb/sv/snap_checker.sv -----
// Checker: predicts the snapped doubles and compares them with the block's results
module snap_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [62:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [63:0] value_bits,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [63:0] result_bits,
    output int          fail_count,
    output int          pending
);
    logic [62:0] lambda_q;
    logic [63:0] snapped_q[$];

    // number of significant bits
    function automatic int bit_len(input logic [63:0] v);
        int r;
        r = 0;
        for (int i = 0; i < 64; i++)
            if (v[i])
                r = i + 1;
        return r;
    endfunction

    // grid exponent m = ceil(log2(lambda))
    function automatic int grid_exp(input logic [62:0] lb);
        int e;
        logic [51:0] f;
        e = lb[62:52];
        f = lb[51:0];
        if (e == 2047)
            return 1024;
        if (e == 0)
        begin
            if (f == 0)
                return -1074;
            if ((f & (f - 1)) == 0)
                return bit_len(64'(f)) - 1075;
            return bit_len(64'(f)) - 1074;
        end
        if (f == 0)
            return e - 1023;
        return e - 1022;
    endfunction

    function automatic logic [63:0] snap(input logic [63:0] x, input logic [62:0] lb);
        logic [63:0] sgn, sig, n, norm;
        int e, m, ex, sh, len, top;
        sgn = {x[63], 63'd0};
        e = x[62:52];
        m = grid_exp(lb);
        if (e == 2047 || (e == 0 && x[51:0] == 0))
            return x;
        if (e == 0)
        begin
            sig = {12'd0, x[51:0]};
            ex = -1074;
        end
        else
        begin
            sig = {11'd0, 1'b1, x[51:0]};
            ex = e - 1075;
        end
        if (m <= ex)
            return x;
        sh = m - ex;
        if (sh >= 55)
            n = 0;
        else
            n = (sig + (64'd1 << (sh - 1))) >> sh;
        if (n == 0)
            return sgn;
        len = bit_len(n);
        top = m + len - 1;
        if (top > 1023)
            return sgn | {1'b0, 11'h7FF, 52'd0};
        if (top >= -1022)
        begin
            norm = (len <= 53) ? (n << (53 - len)) : (n >> 1);
            return sgn | (64'(top + 1023) << 52) | {12'd0, norm[51:0]};
        end
        norm = n << (m + 1074);
        return sgn | {12'd0, norm[51:0]};
    endfunction

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch: %s got %h expected %h", what, got, want);
        fail_count++;
    endtask

    assign pending = snapped_q.size();

    initial fail_count = 0;

    // track register, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lambda_q <= 63'h3FF0000000000000;
            snapped_q.delete();
        end
        else
        begin
            if (cfg_we)
                lambda_q <= cfg_data;
            if (in_valid && !in_stall)
                snapped_q.push_back(snap(value_bits, lambda_q));
            if (out_valid && !out_stall)
            begin
                if (snapped_q.size() == 0)
                    report("unexpected item", result_bits, 64'd0);
                else
                begin
                    if (result_bits !== snapped_q[0])
                        report("result_bits", result_bits, snapped_q[0]);
                    void'(snapped_q.pop_front());
                end
            end
        end
    end
endmodule

// ----- tb/sv/testbench.sv -----
// Testbench top: stimulus, idling, configuration phases and verdict
module testbench;
    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [62:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [63:0] value_bits = '0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [63:0] result_bits;
    int          fail_count, pending;
    int          cycles = 0;
    int          stall_mode = 0;
    logic [62:0] lam_set[8];

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    double_round_to_power_of_two_multiple_unit u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .value_bits(value_bits),
        .out_valid(out_valid), .out_stall(out_stall), .result_bits(result_bits)
    );

    snap_checker u_chk (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .value_bits(value_bits),
        .out_valid(out_valid), .out_stall(out_stall), .result_bits(result_bits),
        .fail_count(fail_count), .pending(pending)
    );

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("testbench: errors");
            $finish;
        end
    end

    // receiver stall pattern, mode changes per phase
    always @(posedge clk)
    begin
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            default: out_stall <= ~out_stall;
        endcase
    end

    // one item through the handshake; valid stays high in bursts
    task automatic send(input logic [63:0] v, input bit hold);
        in_valid <= 1'b1;
        value_bits <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (!hold)
            in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_lambda(input logic [62:0] lb);
        cfg_we <= 1'b1;
        cfg_data <= lb;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // random double biased towards exponents near the grid
    function automatic logic [63:0] rand_value(input logic [62:0] lb);
        logic [63:0] v;
        int e;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: v[62:52] = 11'h7FF;
            1: v[62:52] = '0;
            2: v[62:0] = 63'($urandom_range(0, 3)) << 52;
            3: v[62:52] = 11'h7FE;
            default:
            begin
                e = int'(lb[62:52]) + $urandom_range(0, 120) - 60;
                if (e < 0) e = 0;
                if (e > 2046) e = 2046;
                v[62:52] = 11'(e);
                if ($urandom_range(0, 3) == 0)
                    v[30:0] = '0;
            end
        endcase
        return v;
    endfunction

    initial
    begin
        logic [63:0] directed[$];
        int burst;
        lam_set[0] = 63'h3FF0000000000000;
        lam_set[1] = 63'd0;
        lam_set[2] = 63'd1;
        lam_set[3] = 63'h7FEFFFFFFFFFFFFF;
        lam_set[4] = 63'h7FF0000000000000;
        lam_set[5] = 63'h4010000000000001;
        lam_set[6] = 63'h0000000000008000;
        lam_set[7] = 63'h3FE8000000000000;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, zeros, specials, ties, carries, subnormals
        directed = '{64'h0, 64'h8000000000000000, 64'h7FF0000000000000,
            64'hFFF0000000000000, 64'h7FF8000000000001, 64'hFFFFFFFFFFFFFFFF,
            64'h3FE0000000000000, 64'hBFE0000000000000, 64'h3FF8000000000000,
            64'h3FDFFFFFFFFFFFFF, 64'h4004000000000000, 64'h3FEFFFFFFFFFFFFF,
            64'h7FEFFFFFFFFFFFFF, 64'h0000000000000001, 64'h800FFFFFFFFFFFFF,
            64'h4330000000000001, 64'h432FFFFFFFFFFFFF, 64'h3CB0000000000000,
            64'h5555555555555555, 64'hAAAAAAAAAAAAAAAA};
        foreach (lam_set[i])
        begin
            if (i > 0)
                set_lambda(lam_set[i]);
            foreach (directed[j])
                if (i < 2 || j % 4 == i % 4)
                    send(directed[j], 0);
            drain();
        end

        // random phases with different settings and stall patterns
        for (int ph = 0; ph < 12; ph++)
        begin
            logic [62:0] lb;
            stall_mode = ph % 4;
            if (ph < 8)
                lb = lam_set[ph];
            else
                lb = 63'({$urandom, $urandom});
            if (ph < 8 || lb[62:52] != 11'h7FF)
                set_lambda(lb);
            else
                set_lambda(lam_set[4]);
            lb = u_chk.lambda_q;
            for (int k = 0; k < 150; k += burst)
            begin
                burst = (ph == 5) ? 150 : $urandom_range(1, 12);
                for (int b = 0; b < burst; b++)
                    send(rand_value(lb), b != burst - 1);
                if (ph != 5)
                    repeat ($urandom_range(0, 4)) @(posedge clk);
                if (k == 60)
                    while (pending != 0)
                        @(posedge clk);
            end
            drain();
        end
        stall_mode = 0;
        drain();
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
